// ----- rtl/gmd_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gmd_pkg
// Types, quantizer codes and level tables of the grouped mantissa dequantizer.
// ----------------------------------------------------------------------------
package gmd_pkg;

    typedef struct packed {
        logic               start_block;
        logic [3:0]         bap;
        logic               dither_on;
        logic signed [15:0] dither_value;
        logic [4:0]         exponent;
        logic [15:0]        bit_window;
    } item_t;

    typedef struct packed {
        logic signed [15:0] mantissa_q15;
        logic signed [39:0] coefficient;
        logic [4:0]         bits_used;
        logic               invalid;
    } result_t;

    localparam logic [3:0] BAP_ZERO       = 4'd0;
    localparam logic [3:0] BAP_THREE_LVL  = 4'd1;
    localparam logic [3:0] BAP_FIVE_LVL   = 4'd2;
    localparam logic [3:0] BAP_SEVEN_LVL  = 4'd3;
    localparam logic [3:0] BAP_ELEVEN_LVL = 4'd4;
    localparam logic [3:0] BAP_FIFTEEN_LVL = 4'd5;

    localparam logic [1:0] GROUP_EMPTY = 2'd3;

    localparam logic [4:0] THREE_CODE_MAX  = 5'd26;
    localparam logic [6:0] FIVE_CODE_MAX   = 7'd124;
    localparam logic [6:0] ELEVEN_CODE_MAX = 7'd120;
    localparam logic [2:0] SEVEN_CODE_BAD  = 3'd7;
    localparam logic [3:0] FIFTEEN_CODE_BAD = 4'd15;

    localparam logic [6:0] BASE_3  = 7'd3;
    localparam logic [6:0] BASE_5  = 7'd5;
    localparam logic [6:0] BASE_9  = 7'd9;
    localparam logic [6:0] BASE_11 = 7'd11;
    localparam logic [6:0] BASE_25 = 7'd25;

    // level k of n: ((2k-(n-1)) * 2^15) / n, toward zero; unused slots zero
    localparam logic signed [15:0] LV3 [4] = '{
        -16'sd21845, 16'sd0, 16'sd21845, 16'sd0
    };
    localparam logic signed [15:0] LV5 [8] = '{
        -16'sd26214, -16'sd13107, 16'sd0, 16'sd13107, 16'sd26214,
        16'sd0, 16'sd0, 16'sd0
    };
    localparam logic signed [15:0] LV7 [8] = '{
        -16'sd28086, -16'sd18724, -16'sd9362, 16'sd0, 16'sd9362,
        16'sd18724, 16'sd28086, 16'sd0
    };
    localparam logic signed [15:0] LV11 [16] = '{
        -16'sd29789, -16'sd23831, -16'sd17873, -16'sd11915, -16'sd5957,
        16'sd0, 16'sd5957, 16'sd11915, 16'sd17873, 16'sd23831, 16'sd29789,
        16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0
    };
    localparam logic signed [15:0] LV15 [16] = '{
        -16'sd30583, -16'sd26214, -16'sd21845, -16'sd17476, -16'sd13107,
        -16'sd8738, -16'sd4369, 16'sd0, 16'sd4369, 16'sd8738, 16'sd13107,
        16'sd17476, 16'sd21845, 16'sd26214, 16'sd30583, 16'sd0
    };

    localparam logic [4:0] RAW_BITS [16] = '{
        5'd0, 5'd0, 5'd0, 5'd3, 5'd0, 5'd4, 5'd5, 5'd6,
        5'd7, 5'd8, 5'd9, 5'd10, 5'd11, 5'd12, 5'd14, 5'd16
    };

    // quotient of a narrow code by a constant base, by parallel compares
    function automatic logic [3:0] quot_small(input logic [6:0] v, input logic [6:0] base);
        logic [3:0] q;
        logic [8:0] acc;
        q   = 4'd0;
        acc = {2'b00, base};
        for (int k = 0; k < 10; k++) begin
            if ({2'b00, v} >= acc)
                q = q + 4'd1;
            acc = acc + {2'b00, base};
        end
        return q;
    endfunction

    function automatic logic [6:0] rem_small(input logic [6:0] v, input logic [6:0] base);
        logic [10:0] prod;
        prod = 11'(quot_small(v, base)) * 11'(base);
        return v - prod[6:0];
    endfunction

endpackage

// ----- rtl/gmd_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gmd_core
// Group state and combinational mantissa decode for one registered item.
// ----------------------------------------------------------------------------
module gmd_core
(
    input  logic            clk,
    input  logic            rst_n,
    input  gmd_pkg::item_t  item,
    input  logic            advance,
    output gmd_pkg::result_t result
);

    logic [1:0] t_dig_reg [3];
    logic [1:0] t_nxt_reg;
    logic [2:0] f_dig_reg [3];
    logic [1:0] f_nxt_reg;
    logic [3:0] e_dig_reg [2];
    logic [1:0] e_nxt_reg;

    logic [1:0] t_dig_next [3];
    logic [1:0] t_nxt_next;
    logic [2:0] f_dig_next [3];
    logic [1:0] f_nxt_next;
    logic [3:0] e_dig_next [2];
    logic [1:0] e_nxt_next;

    logic signed [15:0] mant;
    logic [4:0]         used;
    logic               bad;
    logic [1:0]         idx;
    logic [6:0]         code7;
    logic [6:0]         rem;
    logic [3:0]         quo_hi;
    logic [3:0]         quo_mid;
    logic [6:0]         rem_lo;
    logic [1:0]         t_sel;
    logic [2:0]         f_sel;
    logic [3:0]         e_sel;
    logic [15:0]        raw_mask;
    logic signed [39:0] coef_full;

    always_comb
    begin
        if (item.start_block)
        begin
            for (int i = 0; i < 3; i++)
            begin
                t_dig_next[i] = 2'd0;
                f_dig_next[i] = 3'd0;
            end
            for (int i = 0; i < 2; i++)
                e_dig_next[i] = 4'd0;
            t_nxt_next = gmd_pkg::GROUP_EMPTY;
            f_nxt_next = gmd_pkg::GROUP_EMPTY;
            e_nxt_next = gmd_pkg::GROUP_EMPTY;
        end
        else
        begin
            t_dig_next = t_dig_reg;
            f_dig_next = f_dig_reg;
            e_dig_next = e_dig_reg;
            t_nxt_next = t_nxt_reg;
            f_nxt_next = f_nxt_reg;
            e_nxt_next = e_nxt_reg;
        end

        mant     = 16'sd0;
        used     = 5'd0;
        bad      = 1'b0;
        idx      = 2'd0;
        code7    = 7'd0;
        rem      = 7'd0;
        quo_hi   = 4'd0;
        quo_mid  = 4'd0;
        rem_lo   = 7'd0;
        t_sel    = 2'd0;
        f_sel    = 3'd0;
        e_sel    = 4'd0;
        raw_mask = 16'hFFFF;

        unique case (item.bap)
            gmd_pkg::BAP_ZERO:
            begin
                if (item.dither_on)
                    mant = item.dither_value;
            end
            gmd_pkg::BAP_THREE_LVL:
            begin
                idx = t_nxt_next;
                if (t_nxt_next == gmd_pkg::GROUP_EMPTY)
                begin
                    code7 = {2'b00, item.bit_window[15:11]};
                    used  = 5'd5;
                    idx   = 2'd0;
                    if (code7[4:0] > gmd_pkg::THREE_CODE_MAX)
                        bad = 1'b1;
                    else
                    begin
                        rem     = gmd_pkg::rem_small(code7, gmd_pkg::BASE_9);
                        quo_hi  = gmd_pkg::quot_small(code7, gmd_pkg::BASE_9);
                        quo_mid = gmd_pkg::quot_small(rem, gmd_pkg::BASE_3);
                        rem_lo  = gmd_pkg::rem_small(rem, gmd_pkg::BASE_3);
                        t_dig_next[0] = quo_hi[1:0];
                        t_dig_next[1] = quo_mid[1:0];
                        t_dig_next[2] = rem_lo[1:0];
                    end
                end
                if (!bad)
                begin
                    case (idx)
                        2'd0:    t_sel = t_dig_next[0];
                        2'd1:    t_sel = t_dig_next[1];
                        default: t_sel = t_dig_next[2];
                    endcase
                    mant       = gmd_pkg::LV3[t_sel];
                    t_nxt_next = idx + 2'd1;
                end
            end
            gmd_pkg::BAP_FIVE_LVL:
            begin
                idx = f_nxt_next;
                if (f_nxt_next == gmd_pkg::GROUP_EMPTY)
                begin
                    code7 = {item.bit_window[15:9]};
                    used  = 5'd7;
                    idx   = 2'd0;
                    if (code7 > gmd_pkg::FIVE_CODE_MAX)
                        bad = 1'b1;
                    else
                    begin
                        rem     = gmd_pkg::rem_small(code7, gmd_pkg::BASE_25);
                        quo_hi  = gmd_pkg::quot_small(code7, gmd_pkg::BASE_25);
                        quo_mid = gmd_pkg::quot_small(rem, gmd_pkg::BASE_5);
                        rem_lo  = gmd_pkg::rem_small(rem, gmd_pkg::BASE_5);
                        f_dig_next[0] = quo_hi[2:0];
                        f_dig_next[1] = quo_mid[2:0];
                        f_dig_next[2] = rem_lo[2:0];
                    end
                end
                if (!bad)
                begin
                    case (idx)
                        2'd0:    f_sel = f_dig_next[0];
                        2'd1:    f_sel = f_dig_next[1];
                        default: f_sel = f_dig_next[2];
                    endcase
                    mant       = gmd_pkg::LV5[f_sel];
                    f_nxt_next = idx + 2'd1;
                end
            end
            gmd_pkg::BAP_SEVEN_LVL:
            begin
                used = 5'd3;
                if (item.bit_window[15:13] == gmd_pkg::SEVEN_CODE_BAD)
                    bad = 1'b1;
                else
                    mant = gmd_pkg::LV7[item.bit_window[15:13]];
            end
            gmd_pkg::BAP_ELEVEN_LVL:
            begin
                idx = {1'b0, e_nxt_next[0]};
                if (e_nxt_next[1])
                begin
                    code7 = item.bit_window[15:9];
                    used  = 5'd7;
                    idx   = 2'd0;
                    if (code7 > gmd_pkg::ELEVEN_CODE_MAX)
                        bad = 1'b1;
                    else
                    begin
                        quo_hi = gmd_pkg::quot_small(code7, gmd_pkg::BASE_11);
                        rem_lo = gmd_pkg::rem_small(code7, gmd_pkg::BASE_11);
                        e_dig_next[0] = quo_hi;
                        e_dig_next[1] = rem_lo[3:0];
                    end
                end
                if (!bad)
                begin
                    e_sel      = idx[0] ? e_dig_next[1] : e_dig_next[0];
                    mant       = gmd_pkg::LV11[e_sel];
                    e_nxt_next = idx + 2'd1;
                end
            end
            gmd_pkg::BAP_FIFTEEN_LVL:
            begin
                used = 5'd4;
                if (item.bit_window[15:12] == gmd_pkg::FIFTEEN_CODE_BAD)
                    bad = 1'b1;
                else
                    mant = gmd_pkg::LV15[item.bit_window[15:12]];
            end
            default:
            begin
                used     = gmd_pkg::RAW_BITS[item.bap];
                raw_mask = ~(16'hFFFF >> used);
                mant     = $signed(item.bit_window & raw_mask);
            end
        endcase

        coef_full = $signed({mant, 24'd0}) >>> item.exponent;

        result.mantissa_q15 = mant;
        result.coefficient  = coef_full;
        result.bits_used    = used;
        result.invalid      = bad;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 3; i++)
            begin
                t_dig_reg[i] <= 2'd0;
                f_dig_reg[i] <= 3'd0;
            end
            for (int i = 0; i < 2; i++)
                e_dig_reg[i] <= 4'd0;
            t_nxt_reg <= gmd_pkg::GROUP_EMPTY;
            f_nxt_reg <= gmd_pkg::GROUP_EMPTY;
            e_nxt_reg <= gmd_pkg::GROUP_EMPTY;
        end
        else if (advance)
        begin
            t_dig_reg <= t_dig_next;
            f_dig_reg <= f_dig_next;
            e_dig_reg <= e_dig_next;
            t_nxt_reg <= t_nxt_next;
            f_nxt_reg <= f_nxt_next;
            e_nxt_reg <= e_nxt_next;
        end
    end

endmodule

// ----- rtl/grouped_mantissa_dequantizer.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grouped_mantissa_dequantizer
// Decodes one audio mantissa per transfer from its bit allocation code and the
// next sixteen stream bits, with grouped quantizer state kept across items.
//
// Channels: item_valid/item_ready/item carry input items; result_valid/
// result_ready/result carry one result per item, in order.
// Pipeline: input register, then decode logic into the result register.
// Throughput: one item per cycle while the result is not stalled; the group
// state updates as an item moves from the input register into the result
// register, so consecutive items see each other's groups with no bubble.
// Reset: all three mantissa groups are empty, both stages empty.
// Stall: while result_ready is low the result holds; one more item is taken
// into the input register, then item_ready drops until the result moves.
// ----------------------------------------------------------------------------
module grouped_mantissa_dequantizer
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    output logic             item_ready,
    input  gmd_pkg::item_t   item,
    output logic             result_valid,
    input  logic             result_ready,
    output gmd_pkg::result_t result
);

    logic             s1_valid_reg;
    gmd_pkg::item_t   s1_item_reg;
    logic             out_valid_reg;
    gmd_pkg::result_t out_reg;
    gmd_pkg::result_t decoded;
    logic             advance;

    assign advance    = s1_valid_reg && (!out_valid_reg || result_ready);
    assign item_ready = !s1_valid_reg || advance;

    gmd_core u_core
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .item    (s1_item_reg),
        .advance (advance),
        .result  (decoded)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (item_ready)
                s1_valid_reg <= item_valid;
            if (advance)
                out_valid_reg <= 1'b1;
            else if (result_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_valid && item_ready)
            s1_item_reg <= item;
        if (advance)
            out_reg <= decoded;
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

endmodule

// ----- rtl/gmd_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gmd_checker
// Port-level checks on the grouped mantissa dequantizer, bound to the top.
// ----------------------------------------------------------------------------
module gmd_checker
(
    input logic             clk,
    input logic             rst_n,
    input logic             item_valid,
    input logic             item_ready,
    input gmd_pkg::item_t   item,
    input logic             result_valid,
    input logic             result_ready,
    input gmd_pkg::result_t result
);

    a_item_hold: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && !item_ready |=> item_valid && $stable(item))
        else $error("input changed while waiting");

    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result))
        else $error("result changed while stalled");

    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.invalid |->
            result.mantissa_q15 == 16'sd0 && result.coefficient == 40'sd0)
        else $error("invalid result carries a nonzero value");

    a_bits_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> result.bits_used <= 5'd16)
        else $error("bits transfer count out of range");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !item_ready |-> result_valid && !result_ready)
        else $error("input blocked without an output stall");

endmodule

bind grouped_mantissa_dequantizer gmd_checker u_gmd_checker
(
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
);
